// ===== rtl/core/ipmf_pkg.sv =====
// ----------------------------------------------------------------------------
// ipmf_pkg
// Shared types, codes and helpers of the IPv4 mask/compare filter table.
// ----------------------------------------------------------------------------
`default_nettype none
package ipmf_pkg;

  localparam int unsigned TABLE_DEPTH_DEF = 1024;

  localparam logic [1:0] REQ_ADD    = 2'd0;
  localparam logic [1:0] REQ_REMOVE = 2'd1;
  localparam logic [1:0] REQ_CHECK  = 2'd2;
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  localparam logic [1:0] ST_DONE      = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;

  localparam logic [31:0] FREE_MARK  = 32'hffff_ffff;
  localparam logic [7:0]  OCTET_ONES = 8'hff;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [31:0] address;
  } in_beat_t;

  typedef struct packed {
    logic        blocked;
    logic [1:0]  status;
    logic [10:0] entry_count;
  } out_beat_t;

  typedef struct packed {
    logic [31:0] mask;
    logic [31:0] compare;
  } entry_t;

  function automatic logic [31:0] mask_of(input logic [31:0] addr);
    logic [31:0] m;
    m = '0;
    for (int k = 0; k < 4; k++) begin
      if (addr[8*k +: 8] != 8'd0) m[8*k +: 8] = OCTET_ONES;
    end
    return m;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/ipmf_ram.sv =====
// ----------------------------------------------------------------------------
// ipmf_ram
// Entry store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none
module ipmf_ram
  import ipmf_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = TABLE_DEPTH_DEF,
  localparam int unsigned IW = $clog2(TABLE_DEPTH)
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [IW-1:0] waddr,
  input  wire entry_t        wdata,
  input  wire logic [IW-1:0] raddr,
  output entry_t             rdata
);

  entry_t mem [TABLE_DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== rtl/core/ipmf_seq.sv =====
// ----------------------------------------------------------------------------
// ipmf_seq
// Request sequencer: pipelined table scan, slot write and shift-down on remove.
// ----------------------------------------------------------------------------
`default_nettype none
module ipmf_seq
  import ipmf_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = TABLE_DEPTH_DEF,
  localparam int unsigned IW = $clog2(TABLE_DEPTH),
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1)
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire in_beat_t      req,
  input  wire logic          ban_mode,
  output logic               busy,
  output logic               out_valid,
  output out_beat_t          out_data,
  output logic               mem_we,
  output logic [IW-1:0]      mem_waddr,
  output entry_t             mem_wdata,
  output logic [IW-1:0]      mem_raddr,
  input  wire entry_t        mem_rdata
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_SHIFT = 2'd2;

  logic [1:0]    state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] rd_idx_r, rd_idx_nxt;
  logic [IW-1:0] eidx_r, eidx_nxt;
  logic          dv_r, dv_nxt;
  in_beat_t      req_r, req_nxt;
  logic          out_valid_r, out_valid_nxt;
  out_beat_t     out_r, out_nxt;
  logic          hit;
  logic [31:0]   amask;

  assign amask = mask_of(req_r.address);

  always_comb begin
    unique case (req_r.req_type)
      REQ_ADD:    hit = (mem_rdata.compare == FREE_MARK);
      REQ_REMOVE: hit = (mem_rdata.mask == amask) && (mem_rdata.compare == req_r.address);
      REQ_CHECK:  hit = ((req_r.address & mem_rdata.mask) == mem_rdata.compare);
      default:    hit = 1'b0;
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    rd_idx_nxt    = rd_idx_r;
    eidx_nxt      = eidx_r;
    dv_nxt        = 1'b0;
    req_nxt       = req_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    mem_we        = 1'b0;
    mem_waddr     = eidx_r;
    mem_wdata     = mem_rdata;
    mem_raddr     = rd_idx_r[IW-1:0];
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          req_nxt    = req;
          rd_idx_nxt = '0;
          if (req.req_type == REQ_ADD || req.req_type == REQ_REMOVE ||
              req.req_type == REQ_CHECK) begin
            state_nxt = S_SCAN;
          end else begin
            out_valid_nxt = 1'b1;
            out_nxt       = '{blocked: 1'b0, status: ST_DONE, entry_count: 11'(count_r)};
          end
        end
      end
      S_SCAN: begin
        if (dv_r && hit) begin
          unique case (req_r.req_type)
            REQ_ADD: begin
              mem_we        = 1'b1;
              mem_wdata     = '{mask: amask, compare: req_r.address};
              state_nxt     = S_IDLE;
              out_valid_nxt = 1'b1;
              out_nxt       = '{blocked: 1'b0, status: ST_DONE, entry_count: 11'(count_r)};
            end
            REQ_REMOVE: begin
              rd_idx_nxt = CW'(eidx_r) + CW'(1);
              state_nxt  = S_SHIFT;
            end
            default: begin
              state_nxt     = S_IDLE;
              out_valid_nxt = 1'b1;
              out_nxt       = '{blocked: ban_mode, status: ST_DONE,
                                entry_count: 11'(count_r)};
            end
          endcase
        end else if (rd_idx_r < count_r) begin
          dv_nxt     = 1'b1;
          eidx_nxt   = rd_idx_r[IW-1:0];
          rd_idx_nxt = rd_idx_r + CW'(1);
        end else if (!dv_r) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
          unique case (req_r.req_type)
            REQ_ADD: begin
              if (count_r == CW'(TABLE_DEPTH)) begin
                out_nxt = '{blocked: 1'b0, status: ST_FULL, entry_count: 11'(count_r)};
              end else begin
                mem_we    = 1'b1;
                mem_waddr = count_r[IW-1:0];
                mem_wdata = '{mask: amask, compare: req_r.address};
                count_nxt = count_r + CW'(1);
                out_nxt   = '{blocked: 1'b0, status: ST_DONE,
                              entry_count: 11'(count_r + CW'(1))};
              end
            end
            REQ_REMOVE: begin
              out_nxt = '{blocked: 1'b0, status: ST_NOT_FOUND, entry_count: 11'(count_r)};
            end
            default: begin
              out_nxt = '{blocked: ~ban_mode, status: ST_DONE, entry_count: 11'(count_r)};
            end
          endcase
        end
      end
      S_SHIFT: begin
        if (dv_r) begin
          mem_we    = 1'b1;
          mem_waddr = eidx_r - IW'(1);
        end
        if (rd_idx_r < count_r) begin
          dv_nxt     = 1'b1;
          eidx_nxt   = rd_idx_r[IW-1:0];
          rd_idx_nxt = rd_idx_r + CW'(1);
        end else if (!dv_r) begin
          count_nxt     = count_r - CW'(1);
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
          out_nxt       = '{blocked: 1'b0, status: ST_DONE,
                            entry_count: 11'(count_r - CW'(1))};
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      dv_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      dv_r        <= dv_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_idx_r <= rd_idx_nxt;
    eidx_r   <= eidx_nxt;
    req_r    <= req_nxt;
    out_r    <= out_nxt;
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(TABLE_DEPTH)) else $error("entry count beyond depth");
  a_out_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> state_r == S_IDLE) else $error("result while busy");
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && req.req_type != REQ_UNUSED) |=> busy) else $error("request dropped");
  a_shift_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SHIFT && dv_r) |-> eidx_r != '0) else $error("shift below slot zero");

endmodule
`default_nettype wire

// ===== rtl/core/ip_mask_filter_table.sv =====
// ----------------------------------------------------------------------------
// ip_mask_filter_table
// IPv4 mask/compare access list with APB ban_mode register.
// ----------------------------------------------------------------------------
// add, check and a remove that finds nothing strobe their result once the scan has read
//   every slot in use, sooner on an earlier hit; a remove that hits first shifts the
//   later slots down; an unused type is answered from idle without a scan
// throughput: one request at a time, set by the scan of the single entry memory;
//   busy drops with the result strobe and a new request can be accepted in that cycle
// results strobe for one cycle; the receiver cannot stall
// reset: entry count 0, ban_mode 1; entry memory needs no clearing
`default_nettype none
module ip_mask_filter_table
  import ipmf_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = TABLE_DEPTH_DEF,
  localparam int unsigned IW = $clog2(TABLE_DEPTH)
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire in_beat_t    in_data,
  output logic             out_valid,
  output out_beat_t        out_data,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  logic          ban_mode_r;
  logic          mem_we;
  logic [IW-1:0] mem_waddr, mem_raddr;
  entry_t        mem_wdata, mem_rdata;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? {31'd0, ban_mode_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ban_mode_r <= 1'b1;
    end else if (psel && penable && pwrite && !paddr[2]) begin
      ban_mode_r <= pwdata[0];
    end
  end

  ipmf_seq #(.TABLE_DEPTH(TABLE_DEPTH)) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .req       (in_data),
    .ban_mode  (ban_mode_r),
    .busy      (busy),
    .out_valid (out_valid),
    .out_data  (out_data),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  ipmf_ram #(.TABLE_DEPTH(TABLE_DEPTH)) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

endmodule
`default_nettype wire
